FILE: design/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  // pool geometry
  localparam int SLOTS    = 512;
  localparam int RESERVED = 3;
  localparam int FREE_MIN = 2;

  // field widths
  localparam int SLOT_W   = 9;
  localparam int CNT_W    = 10;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC_AT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE     = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_TAKEN = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREE  = 3'd4;

  // cell operation codes
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_MARK = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] granted_slot;
    logic [CNT_W-1:0]  free_count;
  } out_item_t;

  // broadcast control to every cell
  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] key;
  } cell_ctl_t;

  // what one cell hands to its neighbors
  typedef struct packed {
    logic [SLOT_W-1:0] data;
    logic              valid;
    logic              hole;
  } cell_link_t;

  // summary of the whole row for the controller
  typedef struct packed {
    logic [SLOT_W-1:0] top_data;
    logic              any_match;
    logic              any_hole;
  } chain_stat_t;

endpackage

FILE: design/descriptor_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_top
// Slot index allocator over a LIFO free stack built as a row of cells.
// ----------------------------------------------------------------------------
//
//   channel  ports                           payload     direction
//   in       in_valid, in_stall, in_data     in_item_t   request transaction
//   out      out_valid, out_stall, out_data  out_item_t  result transaction
//
// allocate and free first register the request, then search the row and
// commit the stack operation once the output register can take the result
// an allocate_at that removes an entry from the middle of the stack marks it
// and holds off new requests while the gap walks down the cell row one cell
// a cycle until it reaches the bottom of the stack
// synchronous active-low reset loads the initial stack in every cell at once,
// so no clearing pass is needed
// a result waiting on out_stall does not block the next request from being
// registered; it only holds the commit cycle of that request
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_top
  import dsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_COMPACT = 2'd2;

  localparam int RSV_N = (RESERVED > 0) ? RESERVED : 1;

  logic [1:0]       state_r, state_nxt;
  in_item_t         item_r;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  // in-use flags of the reserved slots; for other slots in-use means off stack
  logic [RSV_N-1:0] rsv_r, rsv_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  cell_ctl_t   ctl;
  chain_stat_t stat;

  logic             out_free;
  logic             in_take;
  logic             slot_is_rsv;
  logic             rsv_flag;
  logic             slot_over;
  logic             slot_used;
  logic [CNT_W-1:0] slot_x;
  logic [CNT_W-1:0] top_x;

  dsa_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .push_data (item_r.slot),
    .stat      (stat)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign slot_x    = CNT_W'(item_r.slot);
  assign top_x     = CNT_W'(stat.top_data);
  assign slot_over = (slot_x >= CNT_W'(SLOTS));

  // reserved-slot lookups, one compare per reserved slot
  always_comb begin
    slot_is_rsv = 1'b0;
    rsv_flag    = 1'b0;
    for (int i = 0; i < RESERVED; i++) begin
      if (slot_x == CNT_W'(i)) begin
        slot_is_rsv = 1'b1;
        rsv_flag    = rsv_r[i];
      end
    end
  end

  // a slot outside the reserved range is in use exactly when off the stack
  assign slot_used = slot_is_rsv ? rsv_flag : !stat.any_match;

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    rsv_nxt       = rsv_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.op        = OP_HOLD;
    ctl.key       = item_r.slot;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        // commit only once the output register can take the result
        if (out_free) begin
          res_nxt.status       = ST_RANGE;
          res_nxt.granted_slot = '0;
          state_nxt            = S_IDLE;

          case (item_r.action)
            ACT_ALLOC: begin
              if (depth_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                ctl.op               = OP_POP;
                depth_nxt            = depth_r - CNT_W'(1);
                res_nxt.status       = ST_OK;
                res_nxt.granted_slot = stat.top_data;
                for (int i = 0; i < RESERVED; i++) begin
                  if (top_x == CNT_W'(i)) begin
                    rsv_nxt[i] = 1'b1;
                  end
                end
              end
            end

            ACT_ALLOC_AT: begin
              if (slot_over) begin
                res_nxt.status = ST_RANGE;
              end else if (slot_used) begin
                res_nxt.status = ST_TAKEN;
              end else begin
                res_nxt.status       = ST_OK;
                res_nxt.granted_slot = item_r.slot;
                for (int i = 0; i < RESERVED; i++) begin
                  if (slot_x == CNT_W'(i)) begin
                    rsv_nxt[i] = 1'b1;
                  end
                end
                // entry on the stack: mark it and let the gap close
                if (stat.any_match) begin
                  ctl.op    = OP_MARK;
                  depth_nxt = depth_r - CNT_W'(1);
                  state_nxt = S_COMPACT;
                end
              end
            end

            ACT_FREE: begin
              if (slot_over || (slot_x < CNT_W'(FREE_MIN))) begin
                res_nxt.status = ST_RANGE;
              end else if (!slot_used) begin
                res_nxt.status = ST_FREE;
              end else begin
                res_nxt.status       = ST_OK;
                res_nxt.granted_slot = item_r.slot;
                for (int i = 0; i < RESERVED; i++) begin
                  if (slot_x == CNT_W'(i)) begin
                    rsv_nxt[i] = 1'b0;
                  end
                end
                if (depth_r < CNT_W'(SLOTS)) begin
                  ctl.op    = OP_PUSH;
                  depth_nxt = depth_r + CNT_W'(1);
                end
              end
            end

            default: begin
              res_nxt.status = ST_RANGE;
            end
          endcase

          res_nxt.free_count = depth_nxt;

          if (state_nxt == S_IDLE) begin
            out_nxt       = res_nxt;
            out_valid_nxt = 1'b1;
          end
        end
      end

      S_COMPACT: begin
        // gap has reached the bottom of the stack
        if (!stat.any_hole && out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= CNT_W'(SLOTS - RESERVED);
      rsv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      rsv_r       <= rsv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule

FILE: design/dsa_cell.sv
// ----------------------------------------------------------------------------
// dsa_cell
// One entry of the free stack: holds a slot index, a valid bit and a hole mark.
// ----------------------------------------------------------------------------
module dsa_cell
  import dsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [SLOT_W-1:0] init_data,
  input  logic              init_valid,
  input  cell_link_t        up,
  input  cell_link_t        dn,
  output cell_link_t        self,
  output logic              match
);

  logic [SLOT_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;
  logic              hole_r, hole_nxt;

  assign match = valid_r && (data_r == ctl.key);

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (hole_r) begin
      // close the gap: take the entry below
      data_nxt  = dn.data;
      valid_nxt = dn.valid;
    end else begin
      case (ctl.op)
        OP_PUSH: begin
          data_nxt  = up.data;
          valid_nxt = up.valid;
        end
        OP_POP: begin
          data_nxt  = dn.data;
          valid_nxt = dn.valid;
        end
        default: begin
          data_nxt  = data_r;
          valid_nxt = valid_r;
        end
      endcase
    end
    // hole walks down while there is a valid entry to pull up
    if (ctl.op == OP_MARK) begin
      hole_nxt = match;
    end else begin
      hole_nxt = up.hole && valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r  <= init_data;
      valid_r <= init_valid;
      hole_r  <= 1'b0;
    end else begin
      data_r  <= data_nxt;
      valid_r <= valid_nxt;
      hole_r  <= hole_nxt;
    end
  end

  assign self.data  = data_r;
  assign self.valid = valid_r;
  assign self.hole  = hole_r;

endmodule

FILE: design/dsa_chain.sv
// ----------------------------------------------------------------------------
// dsa_chain
// Row of stack cells, top of stack in cell 0, with row-wide summaries.
// ----------------------------------------------------------------------------
module dsa_chain
  import dsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [SLOT_W-1:0] push_data,
  output chain_stat_t       stat
);

  cell_link_t       link [SLOTS];
  logic [SLOTS-1:0] match_vec;
  logic [SLOTS-1:0] hole_vec;

  cell_link_t top_in;
  cell_link_t bottom_in;

  // pushed value enters at the top, nothing comes up from below the last cell
  assign top_in.data     = push_data;
  assign top_in.valid    = 1'b1;
  assign top_in.hole     = 1'b0;
  assign bottom_in.data  = '0;
  assign bottom_in.valid = 1'b0;
  assign bottom_in.hole  = 1'b0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    cell_link_t up_l;
    cell_link_t dn_l;

    if (k == 0) begin : g_first
      assign up_l = top_in;
    end else begin : g_mid_up
      assign up_l = link[k-1];
    end

    if (k == SLOTS - 1) begin : g_last
      assign dn_l = bottom_in;
    end else begin : g_mid_dn
      assign dn_l = link[k+1];
    end

    // after reset cell k holds RESERVED + k while it lies within the stack
    dsa_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .init_data  (SLOT_W'(RESERVED + k)),
      .init_valid ((k < SLOTS - RESERVED) ? 1'b1 : 1'b0),
      .up         (up_l),
      .dn         (dn_l),
      .self       (link[k]),
      .match      (match_vec[k])
    );

    assign hole_vec[k] = link[k].hole;
  end

  assign stat.top_data  = link[0].data;
  assign stat.any_match = |match_vec;
  assign stat.any_hole  = |hole_vec;

endmodule
